### hdl/lzd_pkg.sv
// Shared types and constants for the LZ77 stream decompressor.
`default_nettype none
package lzd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int REM_W      = 25;
  localparam int LEN_W      = 5;
  localparam logic [LEN_W-1:0] LEN_BASE = LEN_W'(3);
  localparam logic [3:0] FLAG_COUNT = 4'd8;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_MLOW,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } seq_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
  } emit_t;

  typedef struct packed {
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
  } hist_req_t;

endpackage
`default_nettype wire

### hdl/lz77_stream_decompressor.sv
// Top level of the LZ77 stream decompressor with its output register.
`default_nettype none
// Decodes a GBA-BIOS-style LZ77 stream taken one compressed byte per input
// word. Header, flag and copy-high bytes emit nothing; a literal byte emits
// one word. The low byte of a copy token stalls the input until all of its
// 3 to 18 copied bytes are out, since each byte is a registered read of the
// 4096-byte history followed by the write of that byte, and an overlapping
// copy reads the byte just written. The input is also held while a word
// waits in the output register for out_tready. The history needs no
// clearing pass: a fill mark makes reads of entries not yet written since
// the last restart return zero. A word with in_tuser high restarts decoding
// at header byte zero.
module lz77_stream_decompressor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tuser,   // [0] stream_start
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // run_last
  output logic            out_tuser   // [0] stream_done
);

  lzd_pkg::hist_req_t req;
  lzd_pkg::emit_t     emit;
  logic [7:0]         rd_data;
  logic               slot_free;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  assign slot_free = !out_valid_r || out_tready;

  lzd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser),
    .slot_free (slot_free),
    .req       (req),
    .rd_data   (rd_data),
    .emit      (emit)
  );

  lzd_hist u_hist (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_byte_r <= emit.data;
      out_last_r <= emit.last;
      out_done_r <= emit.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule
`default_nettype wire

### hdl/lzd_hist.sv
// History memory: one write port and one registered read port.
`default_nettype none
module lzd_hist (
  input  wire logic               clk,
  input  wire lzd_pkg::hist_req_t req,
  output logic [7:0]              rd_data
);

  logic [7:0] mem_r [lzd_pkg::HIST_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hdl/lzd_ctrl.sv
// Stream parser and copy sequencer of the LZ77 decompressor.
`default_nettype none
module lzd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_start,
  input  wire logic                   slot_free,
  output lzd_pkg::hist_req_t          req,
  input  wire logic [7:0]             rd_data,
  output lzd_pkg::emit_t              emit
);

  localparam int AW = lzd_pkg::HIST_AW;
  localparam int RW = lzd_pkg::REM_W;
  localparam int LW = lzd_pkg::LEN_W;

  lzd_pkg::seq_t   st_r, st_nxt;
  lzd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]    hidx_r, hidx_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [3:0]    fleft_r, fleft_nxt;
  logic [7:0]    mhb_r, mhb_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic          full_r, full_nxt;
  logic [AW-1:0] dist_r, dist_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          rd_ok_r, rd_ok_nxt;

  logic          acc, is_lit, is_copy, emit_go;
  logic [LW-1:0] sub_amt;
  logic [RW-1:0] rem_dif;
  logic [RW-1:0] rem_hdr;
  logic [AW-1:0] rd_addr;
  logic [3:0]    fleft_dec;

  function automatic logic le_zero(input logic [RW-1:0] v);
    le_zero = v[RW-1] || (v == '0);
  endfunction

  assign acc     = in_tvalid && in_tready;
  assign is_lit  = acc && !in_start && (phase_r == lzd_pkg::PH_TOKEN) && !flag_r[7];
  assign is_copy = acc && !in_start && (phase_r == lzd_pkg::PH_MLOW);
  assign emit_go = (st_r == lzd_pkg::ST_EMIT) && slot_free;

  // One subtractor serves both literal and copy tokens.
  assign sub_amt = (phase_r == lzd_pkg::PH_MLOW) ?
                   (lzd_pkg::LEN_BASE + {1'b0, mhb_r[7:4]}) : LW'(1);
  assign rem_dif = rem_r - RW'(sub_amt);
  assign rd_addr = wp_r - dist_r;
  assign fleft_dec = (fleft_r != 4'd0) ? (fleft_r - 4'd1) : 4'd0;

  always_comb begin
    rem_hdr = rem_r;
    unique case (in_start ? 2'd0 : hidx_r)
      2'd0: rem_hdr = '0;
      2'd1: rem_hdr = rem_r | RW'(in_byte);
      2'd2: rem_hdr = rem_r | (RW'(in_byte) << 8);
      2'd3: rem_hdr = rem_r | (RW'(in_byte) << 16);
      default: rem_hdr = rem_r;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lzd_pkg::ST_IDLE: if (is_copy) st_nxt = lzd_pkg::ST_READ;
      lzd_pkg::ST_READ: st_nxt = lzd_pkg::ST_EMIT;
      lzd_pkg::ST_EMIT: begin
        if (emit_go) begin
          st_nxt = (cnt_r == '0) ? lzd_pkg::ST_IDLE : lzd_pkg::ST_READ;
        end
      end
      default: st_nxt = lzd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = (st_r == lzd_pkg::ST_IDLE) && slot_free;
    emit      = '0;
    req       = '0;
    if (is_lit) begin
      emit.valid = 1'b1;
      emit.data  = in_byte;
      emit.last  = 1'b1;
      emit.done  = le_zero(rem_dif);
    end else if (emit_go) begin
      emit.valid = 1'b1;
      emit.data  = rd_ok_r ? rd_data : 8'd0;
      emit.last  = (cnt_r == '0);
      emit.done  = le_zero(rem_r);
    end
    req.wr_en   = emit.valid;
    req.wr_addr = wp_r;
    req.wr_data = emit.data;
    req.rd_en   = (st_r == lzd_pkg::ST_READ);
    req.rd_addr = rd_addr;
  end

  // Parser and datapath registers.
  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    rem_nxt   = rem_r;
    flag_nxt  = flag_r;
    fleft_nxt = fleft_r;
    mhb_nxt   = mhb_r;
    wp_nxt    = wp_r;
    full_nxt  = full_r;
    dist_nxt  = dist_r;
    cnt_nxt   = cnt_r;
    rd_ok_nxt = rd_ok_r;

    if (acc) begin
      priority case (in_start ? lzd_pkg::PH_HEADER : phase_r)
        lzd_pkg::PH_HEADER: begin
          if (in_start) begin
            wp_nxt   = '0;
            full_nxt = 1'b0;
          end
          rem_nxt  = rem_hdr;
          hidx_nxt = (in_start ? 2'd0 : hidx_r) + 2'd1;
          if (!in_start && hidx_r == 2'd3) begin
            phase_nxt = le_zero(rem_hdr) ? lzd_pkg::PH_DONE : lzd_pkg::PH_FLAG;
          end else begin
            phase_nxt = lzd_pkg::PH_HEADER;
          end
        end
        lzd_pkg::PH_FLAG: begin
          flag_nxt  = in_byte;
          fleft_nxt = lzd_pkg::FLAG_COUNT;
          phase_nxt = lzd_pkg::PH_TOKEN;
        end
        lzd_pkg::PH_TOKEN: begin
          if (!flag_r[7]) begin
            rem_nxt   = rem_dif;
            wp_nxt    = wp_r + AW'(1);
            full_nxt  = full_r || (wp_r == '1);
            flag_nxt  = flag_r << 1;
            fleft_nxt = fleft_dec;
            if (le_zero(rem_dif))        phase_nxt = lzd_pkg::PH_DONE;
            else if (fleft_dec == 4'd0)  phase_nxt = lzd_pkg::PH_FLAG;
            else                         phase_nxt = lzd_pkg::PH_TOKEN;
          end else begin
            mhb_nxt   = in_byte;
            phase_nxt = lzd_pkg::PH_MLOW;
          end
        end
        lzd_pkg::PH_MLOW: begin
          rem_nxt  = rem_dif;
          // Distance is field + 1; modulo the history size that is 12 bits.
          dist_nxt = {mhb_r[3:0], in_byte} + AW'(1);
          cnt_nxt  = sub_amt - LW'(1);
        end
        default: ;
      endcase
    end

    if (st_r == lzd_pkg::ST_READ) begin
      // Entries not yet written since the restart read as zero.
      rd_ok_nxt = full_r || (rd_addr < wp_r);
    end

    if (emit_go) begin
      wp_nxt   = wp_r + AW'(1);
      full_nxt = full_r || (wp_r == '1);
      if (cnt_r == '0) begin
        flag_nxt  = flag_r << 1;
        fleft_nxt = fleft_dec;
        if (le_zero(rem_r))          phase_nxt = lzd_pkg::PH_DONE;
        else if (fleft_dec == 4'd0)  phase_nxt = lzd_pkg::PH_FLAG;
        else                         phase_nxt = lzd_pkg::PH_TOKEN;
      end else begin
        cnt_nxt = cnt_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= lzd_pkg::ST_IDLE;
      phase_r <= lzd_pkg::PH_HEADER;
      hidx_r  <= '0;
      rem_r   <= '0;
      flag_r  <= '0;
      fleft_r <= '0;
      mhb_r   <= '0;
      wp_r    <= '0;
      full_r  <= 1'b0;
      cnt_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      rem_r   <= rem_nxt;
      flag_r  <= flag_nxt;
      fleft_r <= fleft_nxt;
      mhb_r   <= mhb_nxt;
      wp_r    <= wp_nxt;
      full_r  <= full_nxt;
      cnt_r   <= cnt_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> slot_free)
    else $error("word emitted while the output register is occupied");

  a_copy_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    is_copy |=> (st_r == lzd_pkg::ST_READ))
    else $error("copy token did not start a history read");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lzd_pkg::ST_IDLE) |-> (cnt_r == '0))
    else $error("copy counter not exhausted when returning to idle");

  a_write_with_emit: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> (emit.valid && !req.rd_en))
    else $error("history write without an emitted word");

endmodule
`default_nettype wire

### tb/tb_lz77_stream_decompressor.sv
// Self-checking testbench for the LZ77 stream decompressor.
`timescale 1ns / 1ps

module tb_lz77_stream_decompressor;
  import lzd_pkg::*;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_word_t;

  // Tracks the decoder state and holds the decompressed bytes still owed.
  class lz77_decode_scoreboard;
    phase_t                  phase;
    logic [1:0]              hdr_idx;
    logic signed [REM_W-1:0] remaining;
    logic [7:0]              flag_byte;
    logic [3:0]              flags_left;
    logic [7:0]              match_hi;
    logic [7:0]              history [HIST_DEPTH];
    logic [HIST_AW-1:0]      wr_pos;
    out_word_t               owed_bytes[$];
    int                      mismatches;

    function void restart();
      phase      = PH_HEADER;
      hdr_idx    = '0;
      remaining  = '0;
      flag_byte  = '0;
      flags_left = '0;
      match_hi   = '0;
      wr_pos     = '0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void push_byte(logic [7:0] b);
      out_word_t w;
      w.data = b;
      w.last = 1'b0;
      w.done = (remaining <= 0);
      owed_bytes.push_back(w);
      history[wr_pos] = b;
      wr_pos++;
    endfunction

    function void finish_token();
      flag_byte = flag_byte << 1;
      if (flags_left > 0) flags_left--;
      if (remaining <= 0) phase = PH_DONE;
      else if (flags_left == 0) phase = PH_FLAG;
      else phase = PH_TOKEN;
    endfunction

    function void note_compressed_byte(logic [7:0] b, logic start);
      int            count_before;
      int            len;
      logic [12:0]   copy_dist;
      logic [HIST_AW-1:0] pos;
      count_before = owed_bytes.size();
      if (start) restart();
      case (phase)
        PH_HEADER: begin
          if (hdr_idx == 0) remaining = '0;
          else remaining = remaining | (REM_W'(b) << (8 * (hdr_idx - 1)));
          if (hdr_idx == 3) begin
            hdr_idx = '0;
            phase = (remaining > 0) ? PH_FLAG : PH_DONE;
          end else begin
            hdr_idx++;
          end
        end
        PH_FLAG: begin
          flag_byte  = b;
          flags_left = FLAG_COUNT;
          phase      = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (!flag_byte[7]) begin
            remaining = remaining - 1;
            push_byte(b);
            finish_token();
          end else begin
            match_hi = b;
            phase = PH_MLOW;
          end
        end
        PH_MLOW: begin
          len  = 3 + match_hi[7:4];
          copy_dist = {1'b0, match_hi[3:0], b} + 13'd1;
          remaining = remaining - REM_W'(len);
          // Bytes are read one at a time so an overlapping copy repeats itself.
          for (int i = 0; i < len; i++) begin
            pos = wr_pos - copy_dist[HIST_AW-1:0];
            push_byte(history[pos]);
          end
          finish_token();
        end
        default: ;
      endcase
      if (owed_bytes.size() > count_before) owed_bytes[owed_bytes.size() - 1].last = 1'b1;
    endfunction

    function void report(string field, logic [7:0] exp_v, logic [7:0] act_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, exp_v, act_v);
    endfunction

    function void check_output_byte(logic [7:0] data, logic last, logic done);
      out_word_t w;
      if (owed_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output word, expected none, actual %02h last %0b done %0b",
                 $time, data, last, done);
        return;
      end
      w = owed_bytes.pop_front();
      if (data !== w.data) report("out_byte", w.data, data);
      if (last !== w.last) report("run_last", 8'(w.last), 8'(last));
      if (done !== w.done) report("stream_done", 8'(w.done), 8'(done));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tuser;   // [0] stream_start
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // run_last
  logic       out_tuser;  // [0] stream_done

  lz77_decode_scoreboard decoder_sb;
  int idle_pct;
  int stall_pct;
  int cycle_count;

  lz77_stream_decompressor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_lz77_stream_decompressor: errors");
      $finish;
    end
  end

  // Output side: values read right after the edge are the ones the edge saw.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        decoder_sb.check_output_byte(out_tdata, out_tlast, out_tuser);
      out_tready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  task automatic send_compressed_byte(logic [7:0] b, logic start);
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    decoder_sb.note_compressed_byte(b, start);
  endtask

  // One stream with random content; some are cut short, some trail ignored bytes.
  task automatic send_stream(inout int counted);
    int         kind;
    int         size;
    int         left;
    int         cut;
    int         tokens;
    bit         stop;
    logic [7:0] flags;
    logic [7:0] hi;
    logic [7:0] lo;
    kind = $urandom_range(0, 19);
    if (kind == 0) size = 0;
    else if (kind == 1) size = $urandom_range(0, 24'hFFFFFF);
    else size = $urandom_range(1, 48);
    cut = (kind == 1 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : -1;
    stop = 1'b0;
    tokens = 0;
    left = size;
    send_compressed_byte(8'($urandom_range(0, 255)), 1'b1);
    send_compressed_byte(size[7:0], 1'b0);
    send_compressed_byte(size[15:8], 1'b0);
    send_compressed_byte(size[23:16], 1'b0);
    counted += 4;
    while (left > 0 && !stop) begin
      if (tokens == cut) begin
        stop = 1'b1;
      end else begin
        flags = 8'($urandom_range(0, 255));
        send_compressed_byte(flags, 1'b0);
        counted++;
        for (int i = 7; i >= 0 && left > 0 && !stop; i--) begin
          if (tokens == cut) begin
            stop = 1'b1;
          end else if (flags[i]) begin
            hi = 8'($urandom_range(0, 255));
            lo = 8'($urandom_range(0, 255));
            // Short distances keep copies inside data that was really written.
            if ($urandom_range(0, 3) != 0) begin
              hi[3:0] = 4'h0;
              lo = 8'($urandom_range(0, 15));
            end
            send_compressed_byte(hi, 1'b0);
            counted++;
            tokens++;
            if (tokens == cut && $urandom_range(0, 1)) begin
              stop = 1'b1;
            end else begin
              send_compressed_byte(lo, 1'b0);
              counted++;
              left -= 3 + hi[7:4];
            end
          end else begin
            send_compressed_byte(8'($urandom_range(0, 255)), 1'b0);
            counted++;
            tokens++;
            left -= 1;
          end
        end
      end
    end
    if (!stop && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_compressed_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int counted;
    decoder_sb = new;
    decoder_sb.restart();
    idle_pct    = 0;
    stall_pct   = 0;
    cycle_count = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Decoding starts from reset without a start flag: size 5, one literal,
    // then a copy of 18 at distance 1 that overshoots the size.
    send_compressed_byte(8'h10, 1'b0);
    send_compressed_byte(8'h05, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h40, 1'b0);
    send_compressed_byte(8'hFF, 1'b0);
    send_compressed_byte(8'hF0, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    // Zero size finishes at once; the byte after it is ignored.
    send_compressed_byte(8'h11, 1'b1);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h5A, 1'b0);
    // Largest size and a longest copy at the largest distance, reading the
    // history before any output was written.
    send_compressed_byte(8'hFF, 1'b1);
    send_compressed_byte(8'hFF, 1'b0);
    send_compressed_byte(8'hFF, 1'b0);
    send_compressed_byte(8'hFF, 1'b0);
    send_compressed_byte(8'hFF, 1'b0);
    send_compressed_byte(8'hFF, 1'b0);
    send_compressed_byte(8'hFF, 1'b0);
    // Restart in the middle of a copy token; size 2 ends exactly at zero
    // after two literals.
    send_compressed_byte(8'h80, 1'b0);
    send_compressed_byte(8'h00, 1'b1);
    send_compressed_byte(8'h02, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h00, 1'b0);
    send_compressed_byte(8'h7E, 1'b0);
    send_compressed_byte(8'h81, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      counted = 0;
      while (counted < 60) send_stream(counted);
    end

    in_tvalid <= 1'b0;
    while (decoder_sb.owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoder_sb.mismatches == 0)
      $display("tb_lz77_stream_decompressor: clean");
    else
      $display("tb_lz77_stream_decompressor: errors");
    $finish;
  end

endmodule
